/* sv/prt_pkg.sv */
// Shared types, constants and the name compare for the peer registration table.
// No dependencies.
package prt_pkg;

	localparam int DEF_TABLE_SLOTS = 16;
	localparam int DEF_NAME_BYTES  = 8;

	localparam int NAME_W  = 64;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int TIME_W  = 32;
	localparam int TMO_W   = 16;
	localparam int SLOT_W  = 6;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd60;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DUMP
	} st_t;

	// Byte-wise compare up to nb bytes; a common zero byte ends the string.
	function automatic logic names_match(input logic [NAME_W-1:0] a,
			input logic [NAME_W-1:0] b, input int nb);
		logic       going;
		logic       res;
		logic [7:0] x;
		logic [7:0] y;
		going = 1'b1;
		res   = 1'b0;
		for (int k = 0; k < NAME_W / 8; k++) begin
			x = a[8*k +: 8];
			y = b[8*k +: 8];
			if (going && (k < nb)) begin
				if (x != y) begin
					going = 1'b0;
				end else if (x == 8'h00) begin
					res   = 1'b1;
					going = 1'b0;
				end
			end
		end
		return res | going;
	endfunction

endpackage

/* sv/peer_registration_table.sv */
// Peer registration table: scan with aging and oldest-slot replacement, then full dump.
// Depends on prt_pkg (types, widths, name compare).
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  req      | in        | req_valid/req_stall  | peer_name, private_*, public_*, now_seconds
//  dump     | out       | dump_valid/dump_stall| entry_*, used_slot, accepted, is_last
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_data = timeout_seconds
//
// req_stall stays high for the whole item: a read-ahead, an evaluation of each slot in turn on
// the shared read port and slot unit, a write step, a read-ahead, then one dump item per cycle
// while the output is not stalled. A new item is taken only once the dump is done; a name hit
// ends the scan at that slot. Dump-side stalls stretch the dump; req_stall drops once the last
// dump item is loaded into the output register.
// Reset is immediate: per-slot valid bits read an unwritten slot as zero.
module peer_registration_table #(
	parameter int TABLE_SLOTS = prt_pkg::DEF_TABLE_SLOTS,
	parameter int NAME_BYTES  = prt_pkg::DEF_NAME_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [prt_pkg::TMO_W-1:0]   cfg_data,
	// registration items
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [prt_pkg::NAME_W-1:0]  peer_name,
	input  logic [prt_pkg::IP_W-1:0]    private_ip,
	input  logic [prt_pkg::PORT_W-1:0]  private_port,
	input  logic [prt_pkg::IP_W-1:0]    public_ip,
	input  logic [prt_pkg::PORT_W-1:0]  public_port,
	input  logic [prt_pkg::TIME_W-1:0]  now_seconds,
	// dump items
	output logic                        dump_valid,
	input  logic                        dump_stall,
	output logic [prt_pkg::SLOT_W-1:0]  entry_index,
	output logic [prt_pkg::NAME_W-1:0]  entry_name,
	output logic [prt_pkg::IP_W-1:0]    entry_private_ip,
	output logic [prt_pkg::PORT_W-1:0]  entry_private_port,
	output logic [prt_pkg::IP_W-1:0]    entry_public_ip,
	output logic [prt_pkg::PORT_W-1:0]  entry_public_port,
	output logic [prt_pkg::SLOT_W-1:0]  used_slot,
	output logic                        accepted,
	output logic                        is_last
);
	import prt_pkg::*;

	localparam int SNAME_W = 8 * NAME_BYTES;               // stored name width
	localparam int ADDR_W  = IP_W + PORT_W;                // ip in high bits, port low
	localparam int ROW_W   = SNAME_W + 2 * ADDR_W;
	localparam int IDX_W   = $clog2(TABLE_SLOTS);
	localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TABLE_SLOTS);
	localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(TABLE_SLOTS - 1);

	// table memories: name + addresses in one, last-seen time in the other
	logic [ROW_W-1:0]  amem [TABLE_SLOTS];
	logic [TIME_W-1:0] tmem [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] a_vld_q;   // aging clears only drop this bit
	logic [TABLE_SLOTS-1:0] t_vld_q;

	st_t state_q, state_d;

	// captured request
	logic [SNAME_W-1:0] name_q;
	logic [ADDR_W-1:0]  priv_q;
	logic [ADDR_W-1:0]  pub_q;
	logic [TIME_W-1:0]  now_q;

	logic [TMO_W-1:0]   tmo_q;

	// scan/dump sequencer
	logic [CNT_W-1:0]   rptr_q;     // next slot to read
	logic [IDX_W-1:0]   eptr_q;     // slot held in read registers
	logic               rdv_q;      // read registers hold a slot
	logic [ROW_W-1:0]   ard_q;
	logic               ardv_q;
	logic [TIME_W-1:0]  trd_q;
	logic               trdv_q;

	// scan result
	logic               found_q;
	logic               refresh_q;
	logic [IDX_W-1:0]   use_q;
	logic [TIME_W-1:0]  best_q;

	// output register
	logic               dump_valid_q;
	logic [SLOT_W-1:0]  entry_index_q;
	logic [NAME_W-1:0]  entry_name_q;
	logic [ADDR_W-1:0]  entry_priv_q;
	logic [ADDR_W-1:0]  entry_pub_q;
	logic [SLOT_W-1:0]  used_slot_q;
	logic               accepted_q;
	logic               is_last_q;

	logic               req_take;
	logic               rd_en;
	logic               consume;
	logic               rptr_lt_n;
	logic [IDX_W-1:0]   raddr;
	logic [ROW_W-1:0]   row;
	logic [TIME_W-1:0]  row_ts;
	logic [SNAME_W-1:0] row_name;
	logic [ADDR_W-1:0]  row_priv;
	logic [ADDR_W-1:0]  row_pub;
	logic               hit;
	logic               older;
	logic               aged;
	logic               scan_end;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;

	assign rptr_lt_n = (rptr_q < SLOTS_C);
	assign raddr     = rptr_q[IDX_W-1:0];

	// unwritten slots read as zero; aged-out slots read a zero row but keep their time
	assign row      = ardv_q ? ard_q : '0;
	assign row_ts   = trdv_q ? trd_q : '0;
	assign row_name = row[ROW_W-1 -: SNAME_W];
	assign row_priv = row[2*ADDR_W-1 -: ADDR_W];
	assign row_pub  = row[ADDR_W-1:0];

	// slot-evaluate unit, shared by every slot of the scan
	assign hit   = names_match(NAME_W'(row_name), NAME_W'(name_q), NAME_BYTES);
	assign older = (row_ts < best_q);
	assign aged  = (({1'b0, row_ts} + {{(TIME_W + 1 - TMO_W){1'b0}}, tmo_q})
			< {1'b0, now_q}) && (row_name[7:0] != 8'h00);
	assign scan_end = rdv_q && (hit || (eptr_q == LAST_C));

	// sequencer outputs
	always_comb begin
		rd_en   = 1'b0;
		consume = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				rd_en = rptr_lt_n;
			end
			ST_DUMP: begin
				consume = rdv_q && (!dump_valid_q || !dump_stall);
				rd_en   = rptr_lt_n && (!rdv_q || consume);
			end
			default: begin
				rd_en   = 1'b0;
				consume = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_DUMP;
			end
			ST_DUMP: begin
				if (consume && (eptr_q == LAST_C)) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory ports: one read, one write each
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ard_q <= amem[raddr];
			trd_q <= tmem[raddr];
		end
		if ((state_q == ST_WRITE) && found_q) begin
			if (!refresh_q) begin
				amem[use_q] <= {8'h00, name_q[SNAME_W-9:0], priv_q, pub_q};
			end
			tmem[use_q] <= now_q;
		end
	end

	// request capture and dump payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			name_q <= peer_name[SNAME_W-1:0];
			priv_q <= {private_ip, private_port};
			pub_q  <= {public_ip, public_port};
			now_q  <= now_seconds;
		end
		if (consume) begin
			entry_index_q <= SLOT_W'(eptr_q);
			entry_name_q  <= NAME_W'(row_name);
			entry_priv_q  <= row_priv;
			entry_pub_q   <= row_pub;
			used_slot_q   <= found_q ? SLOT_W'(use_q) : '0;
			accepted_q    <= found_q;
			is_last_q     <= (eptr_q == LAST_C);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tmo_q        <= TIMEOUT_RST;
			a_vld_q      <= '0;
			t_vld_q      <= '0;
			rptr_q       <= '0;
			eptr_q       <= '0;
			rdv_q        <= 1'b0;
			ardv_q       <= 1'b0;
			trdv_q       <= 1'b0;
			found_q      <= 1'b0;
			refresh_q    <= 1'b0;
			use_q        <= '0;
			best_q       <= '0;
			dump_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) tmo_q <= cfg_data;

			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
				eptr_q <= raddr;
				ardv_q <= a_vld_q[raddr];
				trdv_q <= t_vld_q[raddr];
			end

			if (consume) begin
				dump_valid_q <= 1'b1;
			end else if (!dump_stall) begin
				dump_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					rptr_q    <= '0;
					rdv_q     <= 1'b0;
					found_q   <= 1'b0;
					refresh_q <= 1'b0;
					use_q     <= '0;
					best_q    <= now_seconds;
				end
				ST_SCAN: begin
					rdv_q <= rd_en;
					if (rdv_q) begin
						if (hit) begin
							// name already registered: stop here
							use_q     <= eptr_q;
							found_q   <= 1'b1;
							refresh_q <= (row_pub == pub_q);
						end else begin
							if (older) begin
								use_q   <= eptr_q;
								found_q <= 1'b1;
								best_q  <= row_ts;
							end
							if (aged) a_vld_q[eptr_q] <= 1'b0;
						end
					end
				end
				ST_WRITE: begin
					rptr_q <= '0;
					rdv_q  <= 1'b0;
					if (found_q) begin
						if (!refresh_q) a_vld_q[use_q] <= 1'b1;
						t_vld_q[use_q] <= 1'b1;
					end
				end
				ST_DUMP: begin
					rdv_q <= rd_en || (rdv_q && !consume);
				end
				default: begin
					rdv_q <= 1'b0;
				end
			endcase
		end
	end

	assign dump_valid         = dump_valid_q;
	assign entry_index        = entry_index_q;
	assign entry_name         = entry_name_q;
	assign entry_private_ip   = entry_priv_q[ADDR_W-1 -: IP_W];
	assign entry_private_port = entry_priv_q[PORT_W-1:0];
	assign entry_public_ip    = entry_pub_q[ADDR_W-1 -: IP_W];
	assign entry_public_port  = entry_pub_q[PORT_W-1:0];
	assign used_slot          = used_slot_q;
	assign accepted           = accepted_q;
	assign is_last            = is_last_q;

endmodule
